### src/tsp_pkg.sv
// tsp_pkg: shared types and constants of the timer slot pool
// used by tsp_cell, timer_slot_pool and tsp_checker; no dependencies
package tsp_pkg;

    // pool size limits and field widths
    localparam int unsigned SLOTS_DEF = 8;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned SEL_W     = 8;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_PROC  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    // expiry window after reset
    localparam logic [TICK_W-1:0] WINDOW_RST = 32'h0000_1000;

    // ms to ticks: (ms * 16) / 5 as multiply by ceil(2^22 / 5), shift by 22
    localparam int unsigned SCALED_W   = MS_W + 4;
    localparam int unsigned DIV5_SHIFT = 22;
    localparam int unsigned PROD_W     = 40;
    localparam int unsigned QUOT_W     = PROD_W - DIV5_SHIFT;
    localparam logic [SCALED_W-1:0] DIV5_RECIP = 20'd838861;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              scan_load;
        logic              scan_step;
        logic              tok_clr;
        logic              start_go;
        logic              stop_go;
        logic [SLOT_W-1:0] stop_slot;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] window;
        logic [TICK_W-1:0] deadline;
    } t_cell_ctl;

    // link toward higher slot numbers: scan token and free-slot search
    typedef struct packed {
        logic tok;
        logic free_seen;
    } t_link_up;

    // link toward lower slot numbers: some higher slot still expires
    typedef struct packed {
        logic exp_any;
    } t_link_dn;

    // per-cell status back to the sequencer
    typedef struct packed {
        logic active;
        logic claim;
        logic hit;
        logic last;
    } t_cell_stat;

endpackage

### src/tsp_cell.sv
// tsp_cell: one timer slot of the chain, holding its active bit, deadline and scan token
// depends on tsp_pkg
module tsp_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsp_pkg::t_cell_ctl   i_ctl,
    input  tsp_pkg::t_link_up    i_up,
    input  tsp_pkg::t_link_dn    i_dn,
    output tsp_pkg::t_link_up    o_up,
    output tsp_pkg::t_link_dn    o_dn,
    output tsp_pkg::t_cell_stat  o_stat
);
    import tsp_pkg::*;

    logic              r_active;
    logic              n_active;
    logic              r_tok;
    logic              n_tok;
    logic [TICK_W-1:0] r_deadline;
    logic [TICK_W-1:0] n_deadline;
    logic [TICK_W-1:0] w_ahead;
    logic              w_exp;
    logic              w_claim;
    logic              w_hit;
    logic              w_sel;

    // expiry test: deadline already passed, or too far ahead (wrap guard)
    assign w_ahead = r_deadline - i_ctl.now;
    assign w_exp   = r_active && ((r_deadline < i_ctl.now) || (w_ahead > i_ctl.window));

    // lowest free slot: free here and nothing free below
    assign w_claim = !r_active && !i_up.free_seen;
    assign w_hit   = r_tok && w_exp;
    assign w_sel   = (i_ctl.stop_slot == SLOT_W'(CELL_IDX));

    // neighbor links
    assign o_up.tok       = r_tok;
    assign o_up.free_seen = i_up.free_seen || !r_active;
    assign o_dn.exp_any   = w_exp || i_dn.exp_any;

    // status to the sequencer
    assign o_stat.active = r_active;
    assign o_stat.claim  = w_claim;
    assign o_stat.hit    = w_hit;
    assign o_stat.last   = w_hit && !i_dn.exp_any;

    // next slot state
    always_comb begin
        n_active   = r_active;
        n_deadline = r_deadline;
        if (i_ctl.start_go && w_claim) begin
            n_active   = 1'b1;
            n_deadline = i_ctl.deadline;
        end
        if (i_ctl.stop_go && w_sel && r_active) begin
            n_active   = 1'b0;
            n_deadline = '0;
        end
        if (i_ctl.scan_step && w_hit) begin
            n_active = 1'b0;
        end
    end

    // scan token moves one cell per step
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.tok_clr) begin
            n_tok = 1'b0;
        end else if (i_ctl.scan_step || i_ctl.scan_load) begin
            n_tok = i_up.tok;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tok    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_tok    <= n_tok;
        end
    end

    // deadline payload
    always_ff @(posedge i_clk) begin
        r_deadline <= n_deadline;
    end

endmodule

### src/timer_slot_pool.sv
// timer_slot_pool: start, stop and expiry processing over a chain of timer cells
// start and stop: the item moves to ST_START or ST_STOP, whose one result is registered once the output is free
// process: a token walks one cell per cycle unless a hit is stalled, an expiry result each hit
// one item at a time: a new item is taken only in ST_IDLE, o_stall is high otherwise
// reset (i_rst_n low, synchronous): all slots free, no result pending, window 4096 ticks
// depends on tsp_pkg and tsp_cell
module timer_slot_pool #(
    parameter int unsigned SLOTS = tsp_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic [tsp_pkg::TICK_W-1:0]  i_now,
    input  logic [tsp_pkg::MS_W-1:0]    i_duration_ms,
    input  logic [tsp_pkg::SEL_W-1:0]   i_slot,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic                        o_ok,
    output logic [tsp_pkg::SLOT_W-1:0]  o_result_slot,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsp_pkg::TICK_W-1:0]  i_cfg_data
);
    import tsp_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_STOP  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TICK_W-1:0] r_now;
    logic [QUOT_W-1:0] r_quot;
    logic [SEL_W-1:0]  r_slot;
    logic [TICK_W-1:0] r_window;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic              r_out_ok;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] w_quot;

    logic              e_valid;
    logic [1:0]        e_kind;
    logic              e_ok;
    logic [SLOT_W-1:0] e_slot;
    logic              e_last;

    t_cell_ctl         w_ctl;
    t_link_up          w_up [SLOTS+1];
    t_link_dn          w_dn [SLOTS+1];
    t_cell_stat        w_stat [SLOTS];

    logic              w_hit_any;
    logic              w_last_any;
    logic              w_stop_act;
    logic              w_in_range;
    logic              w_step;
    logic [SLOT_W-1:0] w_claim_idx;
    logic [SLOT_W-1:0] w_hit_idx;

    // handshakes
    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // duration in ticks: (ms * 16) / 5 by reciprocal multiply
    assign w_prod = PROD_W'({i_duration_ms, 4'b0000}) * PROD_W'(DIV5_RECIP);
    assign w_quot = w_prod[DIV5_SHIFT +: QUOT_W];

    // gather cell status
    always_comb begin
        w_hit_any   = 1'b0;
        w_last_any  = 1'b0;
        w_stop_act  = 1'b0;
        w_claim_idx = '0;
        w_hit_idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_hit_any  = w_hit_any | w_stat[i].hit;
            w_last_any = w_last_any | w_stat[i].last;
            if (w_stat[i].active && (r_slot == SEL_W'(i))) begin
                w_stop_act = 1'b1;
            end
            if (w_stat[i].claim) begin
                w_claim_idx = w_claim_idx | SLOT_W'(i);
            end
            if (w_stat[i].hit) begin
                w_hit_idx = w_hit_idx | SLOT_W'(i);
            end
        end
    end

    assign w_in_range = (r_slot < SEL_W'(SLOTS));
    assign w_step     = !w_hit_any || w_out_free;

    // sequencer
    always_comb begin
        n_state          = r_state;
        e_valid          = 1'b0;
        e_kind           = KIND_START;
        e_ok             = 1'b0;
        e_slot           = '0;
        e_last           = 1'b1;
        w_ctl.scan_load  = 1'b0;
        w_ctl.scan_step  = 1'b0;
        w_ctl.tok_clr    = 1'b0;
        w_ctl.start_go   = 1'b0;
        w_ctl.stop_go    = 1'b0;
        w_ctl.stop_slot  = r_slot[SLOT_W-1:0];
        w_ctl.now        = r_now;
        w_ctl.window     = r_window;
        w_ctl.deadline   = r_now + TICK_W'(r_quot);
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_START: n_state = ST_START;
                        MODE_STOP:  n_state = ST_STOP;
                        MODE_PROC: begin
                            n_state         = ST_SCAN;
                            w_ctl.scan_load = 1'b1;
                        end
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    w_ctl.start_go = 1'b1;
                    e_valid        = 1'b1;
                    e_kind         = KIND_START;
                    e_ok           = w_up[SLOTS].free_seen;
                    e_slot         = w_claim_idx;
                    n_state        = ST_IDLE;
                end
            end
            ST_STOP: begin
                if (w_out_free) begin
                    w_ctl.stop_go = w_in_range;
                    e_valid       = 1'b1;
                    e_kind        = KIND_STOP;
                    e_ok          = w_in_range && w_stop_act;
                    n_state       = ST_IDLE;
                end
            end
            ST_SCAN: begin
                w_ctl.scan_step = w_step;
                e_valid         = w_hit_any && w_out_free;
                e_kind          = KIND_EXPIRY;
                e_ok            = 1'b1;
                e_slot          = w_hit_idx;
                e_last          = w_last_any;
                // done once the token leaves the chain or nothing more expires
                if (w_step && (w_up[SLOTS].tok || !w_dn[0].exp_any)) begin
                    w_ctl.tok_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // chain ends
    assign w_up[0].tok       = w_ctl.scan_load;
    assign w_up[0].free_seen = 1'b0;
    assign w_dn[SLOTS].exp_any = 1'b0;

    // row of timer cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tsp_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_up    (w_up[g]),
            .i_dn    (w_dn[g+1]),
            .o_up    (w_up[g+1]),
            .o_dn    (w_dn[g]),
            .o_stat  (w_stat[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_window    <= WINDOW_RST;
        end else begin
            r_state <= n_state;
            if (w_out_free) begin
                r_out_valid <= e_valid;
            end
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_now;
            r_quot <= w_quot;
            r_slot <= i_slot;
        end
        if (e_valid) begin
            r_out_kind <= e_kind;
            r_out_ok   <= e_ok;
            r_out_slot <= e_slot;
            r_out_last <= e_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_ok          = r_out_ok;
    assign o_result_slot = r_out_slot;
    assign o_last        = r_out_last;

endmodule

### src/tsp_checker.sv
// tsp_assertions: port-level checks of the timer slot pool, bound to the top level
// depends on tsp_pkg and timer_slot_pool
module tsp_assertions (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [1:0]                  i_mode,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_kind,
    input logic                        o_ok,
    input logic [tsp_pkg::SLOT_W-1:0]  o_result_slot,
    input logic                        o_last
);
    import tsp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_ok)
            && $stable(o_result_slot) && $stable(o_last))
        else $error("stalled result changed");

    // a start item keeps the block busy in the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == MODE_START) |=> o_stall)
        else $error("start item not held busy");

    // start and stop replies are single results
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_START || o_kind == KIND_STOP) |-> o_last)
        else $error("reply without last");

    // stop replies carry slot zero
    a_stop_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_STOP) |-> (o_result_slot == '0))
        else $error("stop reply with nonzero slot");

    // expiry reports always succeed
    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_EXPIRY) |-> o_ok)
        else $error("expiry report without ok");

endmodule

bind timer_slot_pool tsp_assertions u_tsp_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_mode        (i_mode),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_ok          (o_ok),
    .o_result_slot (o_result_slot),
    .o_last        (o_last)
);
